// File: hw/rtl/septet_packer_hex_out_top_assert.svh
// Assertion macros shared by the checker files of the septet packer.
// Depends on nothing; macros expect clk in scope, and SPK_ASSERT also rst.
`ifndef SEPTET_PACKER_HEX_OUT_TOP_ASSERT_SVH
`define SEPTET_PACKER_HEX_OUT_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SPK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SPK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/spk_pkg.sv
// Shared constants, types and the hex digit function of the septet packer.
// Depends on nothing.
package spk_pkg;

  localparam int CharW  = 8;
  localparam int HexW   = 7;
  localparam int SeptW  = 7;
  localparam int OctW   = 8;

  localparam logic [CharW-1:0] FirstPrint    = 8'd32;
  localparam logic [CharW-1:0] LastPrint     = 8'd126;
  localparam logic [CharW-1:0] MaxCharsReset = 8'd160;

  // Words ready for the output side after one character.
  typedef struct packed {
    logic            err;     // one error word
    logic [2:0]      digits;  // hex digits to send: 0, 1, 2 or 4
    logic [15:0]     octets;  // first octet in the upper byte
  } spk_batch_t;

  function automatic logic [HexW-1:0] hex_ascii(input logic [3:0] nib);
    logic [HexW-1:0] n7;
    n7 = {3'b000, nib};
    if (nib < 4'd10) begin
      return 7'h30 + n7;
    end
    return 7'h41 + (n7 - 7'd10);
  endfunction

endpackage

// File: hw/rtl/spk_if.sv
// Valid/ready channel interfaces of the septet packer: characters in,
// hex digits out, and the register write port. Depends on spk_pkg.
interface spk_item_if;
  logic                     valid;
  logic                     ready;
  logic [spk_pkg::CharW-1:0] text_char;
  logic                     last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface spk_result_if;
  logic                     valid;
  logic                     ready;
  logic [spk_pkg::HexW-1:0] hex_char;
  logic                     run_last;
  logic                     bad_input;

  modport source (output valid, output hex_char, output run_last, output bad_input,
                  input ready);
  modport sink   (input valid, input hex_char, input run_last, input bad_input,
                  output ready);
endinterface

interface spk_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [spk_pkg::CharW-1:0] max_chars;

  modport source (output valid, output max_chars, input ready);
  modport sink   (input valid, input max_chars, output ready);
endinterface

// File: hw/rtl/spk_pack.sv
// Septet packing state, length limit register and the per-character packing
// logic. Depends on spk_pkg.
module spk_pack (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [spk_pkg::CharW-1:0] cfg_max_chars,
  input  logic                      take,
  input  logic [spk_pkg::CharW-1:0] text_char,
  input  logic                      last_char,
  output spk_pkg::spk_batch_t       batch
);

  logic [spk_pkg::CharW-1:0] max_chars;
  logic [spk_pkg::SeptW-1:0] acc;
  logic [2:0]                bits_held;
  logic [spk_pkg::CharW-1:0] chars_seen;

  logic [spk_pkg::SeptW-1:0] acc_next;
  logic [2:0]                bits_held_next;
  logic [spk_pkg::CharW-1:0] chars_seen_next;

  logic        bad;
  logic [13:0] merged;
  logic [3:0]  bit_count;
  logic        full;
  logic [6:0]  rest;

  always_comb begin
    bad       = !(text_char inside {[spk_pkg::FirstPrint:spk_pkg::LastPrint]}) ||
                (chars_seen >= max_chars);
    merged    = {7'd0, acc} | ({7'd0, text_char[6:0]} << bits_held);
    bit_count = {1'b0, bits_held} + 4'd7;
    full      = bit_count[3];
    rest      = full ? {1'b0, merged[13:8]} : merged[6:0];

    batch           = '0;
    acc_next        = rest;
    bits_held_next  = bit_count[2:0];
    chars_seen_next = chars_seen + 8'd1;

    if (bad) begin
      batch.err       = 1'b1;
      batch.digits    = 3'd1;
      acc_next        = '0;
      bits_held_next  = '0;
      chars_seen_next = '0;
    end else begin
      if (full) begin
        batch.digits = 3'd2;
        batch.octets = {merged[7:0], 8'h00};
      end
      if (last_char) begin
        // pad the partial octet with zeros and close the message
        if (full && (bit_count[2:0] != 3'd0)) begin
          batch.digits = 3'd4;
          batch.octets = {merged[7:0], 1'b0, rest};
        end else if (!full) begin
          batch.digits = 3'd2;
          batch.octets = {1'b0, rest, 8'h00};
        end
        acc_next        = '0;
        bits_held_next  = '0;
        chars_seen_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars  <= spk_pkg::MaxCharsReset;
      acc        <= '0;
      bits_held  <= '0;
      chars_seen <= '0;
    end else begin
      if (cfg_write) begin
        max_chars <= cfg_max_chars;
      end
      if (take) begin
        acc        <= acc_next;
        bits_held  <= bits_held_next;
        chars_seen <= chars_seen_next;
      end
    end
  end

endmodule

// File: hw/rtl/spk_emit.sv
// Digit buffer and output register: sends the words of one character as
// hex digits, one per cycle unless stalled. Depends on spk_pkg, spk_if.
module spk_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  spk_pkg::spk_batch_t batch,
  output logic                can_load,
  spk_result_if.source        hex_out
);

  logic [15:0] nibbles;
  logic [2:0]  left;
  logic        err;
  logic        advance;
  logic        send;

  assign advance  = !hex_out.valid || hex_out.ready;
  assign send     = advance && (left != 3'd0);
  // take a new batch once the buffer is empty or drains this cycle
  assign can_load = (left == 3'd0) || ((left == 3'd1) && advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      left          <= '0;
      hex_out.valid <= 1'b0;
    end else begin
      if (send) begin
        hex_out.valid <= 1'b1;
      end else if (hex_out.ready) begin
        hex_out.valid <= 1'b0;
      end
      if (load) begin
        left <= batch.digits;
      end else if (send) begin
        left <= left - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      hex_out.hex_char  <= err ? '0 : spk_pkg::hex_ascii(nibbles[15:12]);
      hex_out.run_last  <= (left == 3'd1);
      hex_out.bad_input <= err;
    end
    if (load) begin
      nibbles <= batch.octets;
      err     <= batch.err;
    end else if (send) begin
      nibbles <= {nibbles[11:0], 4'h0};
    end
  end

endmodule

// File: hw/rtl/septet_packer_hex_out_top.sv
// A taken character's digits load into the digit buffer, then move one by one
// to the output register. Throughput: one hex digit per cycle while the receiver
// is ready; a character is taken when the digit buffer is empty or in the cycle
// its predecessor's last digit moves to the output register.
// Reset (rst, synchronous): packing state and counters clear, max_chars = 160.
//
// Top level of the septet packer. Depends on spk_pkg, spk_if, spk_pack, spk_emit.
module septet_packer_hex_out_top (
  input  logic         clk,
  input  logic         rst,
  spk_cfg_if.sink      cfg,
  spk_item_if.sink     text_in,
  spk_result_if.source hex_out
);

  spk_pkg::spk_batch_t batch;
  logic                can_load;
  logic                take;

  // Register writes are taken at once; user must write only while idle, not enforced.
  assign cfg.ready     = 1'b1;

  // Accept a character whenever the digit buffer is free by the next edge.
  assign text_in.ready = can_load;
  assign take          = text_in.valid && can_load;

  // Pack the 7 low bits of the character into the running bit stream and
  // decide which octets, if any, go out for it.
  spk_pack u_pack (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg.valid && cfg.ready),
    .cfg_max_chars (cfg.max_chars),
    .take          (take),
    .text_char     (text_in.text_char),
    .last_char     (text_in.last_char),
    .batch         (batch)
  );

  // Hold the octets and drain them as hex digits, high nibble first.
  spk_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .batch    (batch),
    .can_load (can_load),
    .hex_out  (hex_out)
  );

endmodule

// File: hw/rtl/spk_check.sv
// Port-level checker of the septet packer and its bind to the top level.
// Depends on septet_packer_hex_out_top_assert.svh.
`include "septet_packer_hex_out_top_assert.svh"

module spk_check (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] hex_char,
  input logic       run_last,
  input logic       bad_input
);

  logic       err_ok;
  logic       digit_ok;
  logic [8:0] word;

  assign err_ok   = (hex_char == 7'd0) && run_last;
  assign digit_ok = ((hex_char >= 7'h30) && (hex_char <= 7'h39)) ||
                    ((hex_char >= 7'h41) && (hex_char <= 7'h46));
  assign word     = {hex_char, run_last, bad_input};

  `SPK_ASSERT(a_err_word, out_valid && bad_input |-> err_ok, "error word malformed")
  `SPK_ASSERT(a_hex_digit, out_valid && !bad_input |-> digit_ok, "not a hex digit")
  `SPK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(word), "word changed")
  `SPK_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "word valid after reset")

endmodule

bind septet_packer_hex_out_top spk_check u_spk_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (hex_out.valid),
  .out_ready (hex_out.ready),
  .hex_char  (hex_out.hex_char),
  .run_last  (hex_out.run_last),
  .bad_input (hex_out.bad_input)
);

// File: sim/testbench.sv
// Self-checking testbench for septet_packer_hex_out_top: random and directed SMS text
// in, hex digits out, each digit checked against a packing predictor kept in step here.
// Depends on spk_pkg, the spk_if channel interfaces and the packer RTL.
module testbench;

  typedef logic [spk_pkg::CharW-1:0] char_t;

  // One character offered to the packer.
  typedef struct packed {
    logic [spk_pkg::CharW-1:0] text_char;
    logic                      last_char;
  } text_word_t;

  // One hex digit the packer must send.
  typedef struct packed {
    logic [spk_pkg::HexW-1:0] hex_char;
    logic                     run_last;
    logic                     bad_input;
  } hex_word_t;

  logic clk = 1'b0;
  logic rst;

  spk_cfg_if    cfg_if ();
  spk_item_if   text_if ();
  spk_result_if hex_if ();

  septet_packer_hex_out_top u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .text_in (text_if),
    .hex_out (hex_if)
  );

  // Characters waiting to go out, and hex digits the packer still owes.
  text_word_t pending_chars[$];
  hex_word_t  hex_words_due[$];
  text_word_t next_word;

  // Packing state mirrored from the block.
  logic [13:0]               pack_acc;
  logic [3:0]                pack_bits;
  logic [7:0]                chars_in_msg;
  logic [spk_pkg::CharW-1:0] max_chars_now;

  // Idling knobs, in percent of cycles.
  int send_idle_pct;
  int recv_stall_pct;

  // Long receiver hold-off: toggle long_hold_arm to request one.
  logic long_hold_arm;
  logic long_hold_seen;
  int   long_hold_left;

  int   mismatches = 0;
  logic leftover;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [spk_pkg::HexW-1:0] nibble_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? 7'h30 + {3'b000, nib} : 7'h37 + {3'b000, nib};
  endfunction

  // Advance the packing state by one accepted character and queue the digits it causes.
  function automatic void pack_char(input logic [spk_pkg::CharW-1:0] c, input logic is_last);
    logic [7:0] octs [2];
    int         n_oct;
    hex_word_t  w;
    n_oct = 0;
    // Unprintable or over-length character: one error word, state cleared.
    if (c < spk_pkg::FirstPrint || c > spk_pkg::LastPrint || chars_in_msg >= max_chars_now) begin
      pack_acc     = '0;
      pack_bits    = '0;
      chars_in_msg = '0;
      w = '{hex_char: '0, run_last: 1'b1, bad_input: 1'b1};
      hex_words_due.push_back(w);
      return;
    end
    pack_acc     = pack_acc | ({7'd0, c[6:0]} << pack_bits);
    pack_bits    = pack_bits + 4'd7;
    chars_in_msg = chars_in_msg + 8'd1;
    if (pack_bits >= 4'd8) begin
      octs[n_oct] = pack_acc[7:0];
      n_oct       = n_oct + 1;
      pack_acc    = pack_acc >> 8;
      pack_bits   = pack_bits - 4'd8;
    end
    // Flush the partial octet on the last character, upper bits zero.
    if (is_last) begin
      if (pack_bits != 4'd0) begin
        octs[n_oct] = pack_acc[7:0];
        n_oct       = n_oct + 1;
      end
      pack_acc     = '0;
      pack_bits    = '0;
      chars_in_msg = '0;
    end
    for (int i = 0; i < 2 * n_oct; i++) begin
      w.hex_char  = (i % 2 == 0) ? nibble_ascii(octs[i / 2][7:4])
                                 : nibble_ascii(octs[i / 2][3:0]);
      w.run_last  = (i == 2 * n_oct - 1);
      w.bad_input = 1'b0;
      hex_words_due.push_back(w);
    end
  endfunction

  // Driver: hold a word until it is taken, then offer the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      text_if.valid     <= 1'b0;
      text_if.text_char <= '0;
      text_if.last_char <= 1'b0;
      pack_acc     = '0;
      pack_bits    = '0;
      chars_in_msg = '0;
    end else begin
      if (text_if.valid && text_if.ready) begin
        pack_char(text_if.text_char, text_if.last_char);
      end
      if (!text_if.valid || text_if.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_word = pending_chars.pop_front();
          text_if.valid     <= 1'b1;
          text_if.text_char <= next_word.text_char;
          text_if.last_char <= next_word.last_char;
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      hex_if.ready   <= 1'b0;
      long_hold_seen <= 1'b0;
      long_hold_left <= 0;
    end else if (long_hold_left > 0) begin
      hex_if.ready   <= 1'b0;
      long_hold_left <= long_hold_left - 1;
    end else if (long_hold_arm != long_hold_seen) begin
      hex_if.ready   <= 1'b0;
      long_hold_seen <= long_hold_arm;
      long_hold_left <= 80;
    end else begin
      hex_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: compare every accepted digit with the oldest one due.
  always @(posedge clk) begin
    hex_word_t due;
    if (!rst && hex_if.valid && hex_if.ready) begin
      if (hex_words_due.size() == 0) begin
        $error("unexpected hex word: hex_char %h run_last %b bad_input %b",
               hex_if.hex_char, hex_if.run_last, hex_if.bad_input);
        mismatches = mismatches + 1;
      end else begin
        due = hex_words_due.pop_front();
        if (hex_if.hex_char !== due.hex_char) begin
          $error("hex_char: expected %h, actual %h", due.hex_char, hex_if.hex_char);
          mismatches = mismatches + 1;
        end
        if (hex_if.run_last !== due.run_last) begin
          $error("run_last: expected %b, actual %b", due.run_last, hex_if.run_last);
          mismatches = mismatches + 1;
        end
        if (hex_if.bad_input !== due.bad_input) begin
          $error("bad_input: expected %b, actual %b", due.bad_input, hex_if.bad_input);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  task automatic queue_char(input logic [spk_pkg::CharW-1:0] c, input logic is_last);
    text_word_t w;
    w.text_char = c;
    w.last_char = is_last;
    pending_chars.push_back(w);
  endtask

  // Queue one message of len characters; each is unprintable with noise_pct percent odds.
  task automatic queue_message(input int len, input int noise_pct);
    logic [spk_pkg::CharW-1:0] c;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        c = $urandom_range(0, 1) ? char_t'($urandom_range(0, 31))
                                 : char_t'($urandom_range(127, 255));
      end else begin
        c = char_t'($urandom_range(32, 126));
      end
      queue_char(c, i == len - 1);
    end
  endtask

  // Mostly clean messages; the rest noisy or longer than max_chars allows.
  task automatic queue_traffic(input int n_items);
    int count;
    int len;
    int pick;
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = $urandom_range(1, (max_chars_now < 24) ? int'(max_chars_now) : 24);
        queue_message(len, 0);
      end else if (pick < 90) begin
        len = $urandom_range(1, 12);
        queue_message(len, 20);
      end else if (max_chars_now <= 24) begin
        len = int'(max_chars_now) + $urandom_range(1, 3);
        queue_message(len, 0);
      end else begin
        len = 1;
        queue_message(len, 100);
      end
      count += len;
    end
  endtask

  // Wait until every character is taken and every digit has arrived, then settle.
  task automatic drain;
    int n;
    n = 0;
    while ((pending_chars.size() != 0 || text_if.valid || hex_words_due.size() != 0)
           && n < 50000) begin
      @(posedge clk);
      n++;
    end
    // A character that causes no digit may still be in flight.
    repeat (4) @(posedge clk);
    if (hex_words_due.size() != 0) leftover = 1'b1;
  endtask

  // Write max_chars through the register channel while the packer is idle.
  task automatic write_max_chars(input logic [spk_pkg::CharW-1:0] value);
    @(posedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.max_chars <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid  <= 1'b0;
    max_chars_now = value;
  endtask

  initial begin
    rst              = 1'b1;
    cfg_if.valid     = 1'b0;
    cfg_if.max_chars = '0;
    long_hold_arm  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    leftover       = 1'b0;
    max_chars_now  = spk_pkg::MaxCharsReset;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, with the reset max_chars: single chars, printable extremes,
    // an exact 8-character fit with no padding octet, unprintable bytes with
    // and without last, a first char with no digit, and an error mid-message.
    queue_char("A", 1'b1);
    queue_char(8'd32, 1'b1);
    queue_char(8'd126, 1'b1);
    for (int i = 0; i < 8; i++) queue_char("x", i == 7);
    queue_char(8'd0, 1'b0);
    queue_char(8'd255, 1'b1);
    queue_char(8'd31, 1'b0);
    queue_char(8'd127, 1'b0);
    queue_char(8'd128, 1'b1);
    queue_char("H", 1'b0);
    queue_char("i", 1'b1);
    queue_char("a", 1'b0);
    queue_char("b", 1'b0);
    queue_char(8'h05, 1'b0);
    queue_char("c", 1'b1);
    drain();

    // One character per message: the second one is too long.
    write_max_chars(8'd1);
    queue_char("Z", 1'b0);
    queue_char("Y", 1'b1);
    queue_char("Q", 1'b1);
    drain();

    // Zero max_chars rejects everything.
    write_max_chars(8'd0);
    queue_char("A", 1'b1);
    queue_char("B", 1'b0);
    drain();

    // Widest limit, no idling.
    write_max_chars(8'd255);
    queue_traffic(60);
    drain();

    // Reset value again, sender mostly idle.
    send_idle_pct = 74;
    write_max_chars(spk_pkg::MaxCharsReset);
    queue_traffic(60);
    drain();

    // Short limit, receiver mostly stalled, and one long hold-off while the
    // sender keeps offering so the output fills and the input stalls.
    send_idle_pct  = 0;
    recv_stall_pct = 74;
    write_max_chars(char_t'($urandom_range(1, 12)));
    queue_traffic(60);
    long_hold_arm = ~long_hold_arm;
    drain();

    // Any legal limit, light idling on both sides.
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    write_max_chars(char_t'($urandom_range(1, 255)));
    queue_traffic(60);
    drain();

    if (mismatches == 0 && !leftover) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/spk_pkg.sv
hw/rtl/spk_if.sv
hw/rtl/spk_pack.sv
hw/rtl/spk_emit.sv
hw/rtl/septet_packer_hex_out_top.sv
hw/rtl/spk_check.sv
sim/testbench.sv
